FILE: design/kl_pkg.sv
// Shared types and codes for the keyed list block.
// Used by the stream interfaces, the output register and the top level.
package kl_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  // Status codes of a result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // One stored entry, as it sits in the entry memory.
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] payload;
    logic        urgent;
  } entry_t;

  // One request.
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
    logic [31:0] payload;
    logic        urgent;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_key;
    logic [31:0] found_payload;
    logic        found_urgent;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;

endpackage

FILE: design/kl_stream_if.sv
// Valid/ready stream interfaces for requests and results of the keyed list.
// Depends on kl_pkg for the payload types.
interface kl_req_if import kl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kl_rsp_if import kl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/keyed_list_front_back_insert.sv
// Keyed ordered list in a circular buffer in one RAM. Search reads one entry per cycle.
// Delete searches, then moves each entry behind the removed one one slot down, read then write.
// List reads each entry in turn and hands it to the output register when that has room.
// One request at a time; the next is taken after its last result.
// Reset clears the count and the head pointer at once; the RAM is not cleared.
// Depends on kl_pkg, kl_stream_if, kl_ram and kl_outbuf.
module keyed_list_front_back_insert import kl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  kl_req_if.sink   req_i,
  kl_rsp_if.source rsp_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHRD  = 3'd2;
  localparam logic [2:0] S_SHWR  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_LSRD  = 3'd5;
  localparam logic [2:0] S_LSOUT = 3'd6;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : AW'(p - 1'b1);
  endfunction

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [1:0]    op_q, op_d;
  logic [63:0]   key_q, key_d;
  rsp_t          res_q, res_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic          out_load, out_free;
  rsp_t          out_data;
  logic          hit;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_ptr;

  // Entry memory.
  kl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register toward the consumer.
  kl_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .data_i (out_data),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

  // Physical slot behind the last entry; the sum stays below twice the depth.
  assign tail_sum = SW'(head_q) + SW'(cnt_q);
  assign tail_ptr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  assign hit = rd_vld_q && (ram_rdata.key == key_q);

  // Sequencer: read, compare, move and emit one step at a time.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    rd_ptr_d  = rd_ptr_q;
    rem_d     = rem_q;
    op_d      = op_q;
    key_d     = key_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = ram_rdata;
    out_load  = 1'b0;
    out_data  = res_q;
    out_data.entry_count = 5'(cnt_q);
    out_data.last        = 1'b1;
    req_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d     = req_i.data.operation;
          key_d    = req_i.data.key;
          idx_d    = '0;
          ptr_d    = head_q;
          rd_vld_d = 1'b0;
          res_d    = '0;
          case (req_i.data.operation)
            OP_ADD: begin
              state_d = S_EMIT;
              if (cnt_q == CW'(DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.status      = ST_OK;
                ram_we            = 1'b1;
                ram_wdata.key     = req_i.data.key;
                ram_wdata.payload = req_i.data.payload;
                ram_wdata.urgent  = req_i.data.urgent;
                cnt_d             = CW'(cnt_q + 1'b1);
                if (req_i.data.urgent) begin
                  ram_waddr = ptr_dec(head_q);
                  head_d    = ptr_dec(head_q);
                end else begin
                  ram_waddr = tail_ptr;
                end
              end
            end
            OP_SEARCH: begin
              state_d = S_SCAN;
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_LIST: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                state_d = S_LSRD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // One read issued per cycle; the previous read is compared.
      S_SCAN: begin
        if (hit) begin
          res_d.status        = ST_OK;
          res_d.found_key     = ram_rdata.key;
          res_d.found_payload = ram_rdata.payload;
          res_d.found_urgent  = ram_rdata.urgent;
          rd_vld_d            = 1'b0;
          if (op_q == OP_DELETE) begin
            ptr_d   = rd_ptr_q;
            rem_d   = CW'(cnt_q - rd_idx_q - 1'b1);
            state_d = S_SHRD;
          end else begin
            state_d = S_EMIT;
          end
        end else if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_q;
          rd_ptr_d  = ptr_q;
          idx_d     = CW'(idx_q + 1'b1);
          ptr_d     = ptr_inc(ptr_q);
        end else begin
          rd_vld_d = 1'b0;
          if (!rd_vld_q) begin
            res_d.status = ST_NOT_FOUND;
            state_d      = S_EMIT;
          end
        end
      end

      // Close the gap: read the next entry, then write it one slot down.
      S_SHRD: begin
        if (rem_q == '0) begin
          cnt_d   = CW'(cnt_q - 1'b1);
          state_d = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc(ptr_q);
          state_d   = S_SHWR;
        end
      end

      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_inc(ptr_q);
        rem_d     = CW'(rem_q - 1'b1);
        state_d   = S_SHRD;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Listing: read one entry, then hand it to the output register.
      S_LSRD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
        ptr_d     = ptr_inc(ptr_q);
        state_d   = S_LSOUT;
      end

      S_LSOUT: begin
        out_data.status        = ST_OK;
        out_data.found_key     = ram_rdata.key;
        out_data.found_payload = ram_rdata.payload;
        out_data.found_urgent  = ram_rdata.urgent;
        out_data.last          = (CW'(idx_q + 1'b1) == cnt_q);
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = CW'(idx_q + 1'b1);
          state_d  = out_data.last ? S_IDLE : S_LSRD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      head_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ptr_q    <= ptr_d;
    rd_idx_q <= rd_idx_d;
    rd_ptr_q <= rd_ptr_d;
    rem_q    <= rem_d;
    op_q     <= op_d;
    key_q    <= key_d;
    res_q    <= res_d;
  end

  // The entry count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds capacity");

  // The RAM is never written and read at the same slot in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("RAM read and write collide");

  // Work starts only after a request has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !(req_i.valid && req_i.ready)) |=> (state_q == S_IDLE))
    else $error("sequencer left idle without a request");

  // A result is loaded only when the output register has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |-> out_free)
    else $error("result loaded into a full output register");

endmodule

FILE: design/kl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/kl_outbuf.sv
// Output register of the keyed list: holds one result until it is taken.
// Depends on kl_pkg and the kl_rsp_if interface.
module kl_outbuf import kl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  rsp_t     data_i,
  output logic     free_o,
  kl_rsp_if.source rsp_o
);

  logic valid_q;
  rsp_t data_q;

  // The slot can take a new result when empty or when being emptied now.
  assign free_o = !valid_q || rsp_o.ready;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid = valid_q;
  assign rsp_o.data  = data_q;

endmodule
